>>> rtl/ptc_pkg.sv
package ptc_pkg;

   localparam int COEF_W   = 16;
   localparam int RAW_W    = 24;
   localparam int DT_W     = 25;
   localparam int TEMP_W   = 19;
   localparam int PRESS_W  = 41;
   localparam int CSR_IDX_W = 3;

   // internal widths
   localparam int OFF_W    = 37;
   localparam int SENS_W   = 36;
   localparam int OFFI_W   = 38;
   localparam int SENSI_W  = 37;

   localparam logic [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);

   localparam logic [CSR_IDX_W-1:0] CSR_C1 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_C2 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_C3 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_C4 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_C5 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_C6 = CSR_IDX_W'(5);

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_type;

   // word handed from the temperature front end to the pressure back end
   typedef struct packed {
      logic [RAW_W-1:0]   d1;
      logic [DT_W-1:0]    dt;
      logic [TEMP_W-1:0]  temp;
      logic [TEMP_W-1:0]  temp2;
      logic [OFF_W-1:0]   off;
      logic [OFFI_W-1:0]  offi;
      logic [SENS_W-1:0]  sens;
      logic [SENSI_W-1:0] sensi;
   } mid_type;

endpackage

>>> rtl/ptc_csr.sv
module ptc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ptc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]    csr_wdata,
   output ptc_pkg::coef_type             coef
);
   import ptc_pkg::*;

   coef_type coef_ff;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_C1:  coef_ff.c1 <= csr_wdata;
            CSR_C2:  coef_ff.c2 <= csr_wdata;
            CSR_C3:  coef_ff.c3 <= csr_wdata;
            CSR_C4:  coef_ff.c4 <= csr_wdata;
            CSR_C5:  coef_ff.c5 <= csr_wdata;
            CSR_C6:  coef_ff.c6 <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/ptc_temp.sv
module ptc_temp (
   input  logic                      clock,
   input  logic                      reset,
   input  ptc_pkg::coef_type         coef,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [ptc_pkg::RAW_W-1:0] in_d2,
   input  logic [ptc_pkg::RAW_W-1:0] in_d1,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ptc_pkg::mid_type          out_word
);
   import ptc_pkg::*;

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE:0]   en;

   // stage 1: temperature difference
   logic        [DT_W-1:0]  s1_dt_in;
   logic signed [DT_W-1:0]  s1_dt_ff;
   logic        [RAW_W-1:0] s1_d1_ff;

   // stage 2: products with dT
   logic signed [41:0]      s2_mt_in, s2_moff_in, s2_msens_in;
   logic signed [49:0]      s2_mdd_in;
   logic signed [41:0]      s2_mt_ff, s2_moff_ff, s2_msens_ff;
   logic signed [49:0]      s2_mdd_ff;
   logic        [DT_W-1:0]  s2_dt_ff;
   logic        [RAW_W-1:0] s2_d1_ff;

   // stage 3: first-order results
   logic [53:0]         s3_dd11;
   logic [TEMP_W-1:0]   s3_e_in, s3_temp_in, s3_ti_in;
   logic [OFF_W-1:0]    s3_off_in;
   logic [SENS_W-1:0]   s3_sens_in;
   logic [TEMP_W-1:0]   s3_e_ff, s3_temp_ff, s3_ti_ff;
   logic                s3_low_ff;
   logic [OFF_W-1:0]    s3_off_ff;
   logic [SENS_W-1:0]   s3_sens_ff;
   logic [DT_W-1:0]     s3_dt_ff;
   logic [RAW_W-1:0]    s3_d1_ff;

   // stage 4: squared temperature error and second-order temperature
   logic signed [37:0]  s4_ee_in;
   logic [TEMP_W-1:0]   s4_temp2_in;
   logic [35:0]         s4_ee_ff;
   logic [TEMP_W-1:0]   s4_temp_ff, s4_temp2_ff;
   logic                s4_low_ff;
   logic [OFF_W-1:0]    s4_off_ff;
   logic [SENS_W-1:0]   s4_sens_ff;
   logic [DT_W-1:0]     s4_dt_ff;
   logic [RAW_W-1:0]    s4_d1_ff;

   // stage 5: low-temperature offset and sensitivity terms
   logic [40:0]         s5_ee31;
   logic [41:0]         s5_ee63;
   logic [OFFI_W-1:0]   s5_offi_in;
   logic [SENSI_W-1:0]  s5_sensi_in;
   mid_type             s5_ff;

   always_comb begin
      en[NSTAGE] = out_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_word  = s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign s1_dt_in = {1'b0, in_d2} - {1'b0, coef.c5, 8'b0};

   assign s2_mt_in    = s1_dt_ff * $signed({1'b0, coef.c6});
   assign s2_moff_in  = s1_dt_ff * $signed({1'b0, coef.c4});
   assign s2_msens_in = s1_dt_ff * $signed({1'b0, coef.c3});
   assign s2_mdd_in   = s1_dt_ff * s1_dt_ff;

   // floor shifts are plain part-selects of the signed products
   assign s3_e_in    = s2_mt_ff[41:23];
   assign s3_temp_in = s3_e_in + TEMP_REF;
   assign s3_off_in  = {4'b0, coef.c2, 17'b0} + {s2_moff_ff[41], s2_moff_ff[41:6]};
   assign s3_sens_in = {4'b0, coef.c1, 16'b0} + {s2_msens_ff[41], s2_msens_ff[41:7]};
   // dT squared is never negative: 11*x as shift-and-add
   assign s3_dd11    = {1'b0, s2_mdd_ff, 3'b0} + {3'b0, s2_mdd_ff, 1'b0}
                     + {4'b0, s2_mdd_ff};
   assign s3_ti_in   = s3_dd11[53:35];

   assign s4_ee_in    = $signed(s3_e_ff) * $signed(s3_e_ff);
   assign s4_temp2_in = s3_temp_ff - (s3_low_ff ? s3_ti_ff : '0);

   assign s5_ee31     = {s4_ee_ff, 5'b0} - {5'b0, s4_ee_ff};
   assign s5_ee63     = {s4_ee_ff, 6'b0} - {6'b0, s4_ee_ff};
   assign s5_offi_in  = s4_low_ff ? s5_ee31[40:3] : '0;
   assign s5_sensi_in = s4_low_ff ? s5_ee63[41:5] : '0;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= in_d1;
      end
      if (en[1]) begin
         s2_mt_ff    <= s2_mt_in;
         s2_moff_ff  <= s2_moff_in;
         s2_msens_ff <= s2_msens_in;
         s2_mdd_ff   <= s2_mdd_in;
         s2_dt_ff    <= s1_dt_ff;
         s2_d1_ff    <= s1_d1_ff;
      end
      if (en[2]) begin
         s3_e_ff    <= s3_e_in;
         s3_temp_ff <= s3_temp_in;
         s3_ti_ff   <= s3_ti_in;
         s3_low_ff  <= s2_mt_ff[41];
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_dt_ff   <= s2_dt_ff;
         s3_d1_ff   <= s2_d1_ff;
      end
      if (en[3]) begin
         s4_ee_ff    <= s4_ee_in[35:0];
         s4_temp_ff  <= s3_temp_ff;
         s4_temp2_ff <= s4_temp2_in;
         s4_low_ff   <= s3_low_ff;
         s4_off_ff   <= s3_off_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_dt_ff    <= s3_dt_ff;
         s4_d1_ff    <= s3_d1_ff;
      end
      if (en[4]) begin
         s5_ff.d1    <= s4_d1_ff;
         s5_ff.dt    <= s4_dt_ff;
         s5_ff.temp  <= s4_temp_ff;
         s5_ff.temp2 <= s4_temp2_ff;
         s5_ff.off   <= s4_off_ff;
         s5_ff.offi  <= s5_offi_in;
         s5_ff.sens  <= s4_sens_ff;
         s5_ff.sensi <= s5_sensi_in;
      end
   end

endmodule

>>> rtl/ptc_press.sv
module ptc_press (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ptc_pkg::mid_type            in_word,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ptc_pkg::TEMP_W-1:0]  out_temp2,
   output logic [ptc_pkg::TEMP_W-1:0]  out_temp,
   output logic [ptc_pkg::DT_W-1:0]    out_dt,
   output logic [ptc_pkg::PRESS_W-1:0] out_press
);
   import ptc_pkg::*;

   localparam int NSTAGE = 4;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE:0]   en;

   // stage 6: corrected offset and sensitivity
   logic [38:0]        s6_od_in, s6_od_ff;
   logic [37:0]        s6_sd_in, s6_sd_ff;
   logic [RAW_W-1:0]   s6_d1_ff;
   logic [TEMP_W-1:0]  s6_temp_ff, s6_temp2_ff;
   logic [DT_W-1:0]    s6_dt_ff;

   // stage 7: partial products of D1 and the sensitivity
   logic [42:0]        s7_pl_in, s7_pl_ff;
   logic signed [43:0] s7_ph_in, s7_ph_ff;
   logic [38:0]        s7_od_ff;
   logic [TEMP_W-1:0]  s7_temp_ff, s7_temp2_ff;
   logic [DT_W-1:0]    s7_dt_ff;

   // stage 8: full product
   logic [62:0]        s8_prod_in, s8_prod_ff;
   logic [38:0]        s8_od_ff;
   logic [TEMP_W-1:0]  s8_temp_ff, s8_temp2_ff;
   logic [DT_W-1:0]    s8_dt_ff;

   // stage 9: output register
   logic [PRESS_W-1:0] s9_press_in, s9_press_ff;
   logic [TEMP_W-1:0]  s9_temp_ff, s9_temp2_ff;
   logic [DT_W-1:0]    s9_dt_ff;

   always_comb begin
      en[NSTAGE] = out_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_temp2 = s9_temp2_ff;
   assign out_temp  = s9_temp_ff;
   assign out_dt    = s9_dt_ff;
   assign out_press = s9_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign s6_od_in = {{2{in_word.off[OFF_W-1]}}, in_word.off} - {1'b0, in_word.offi};
   assign s6_sd_in = {{2{in_word.sens[SENS_W-1]}}, in_word.sens} - {1'b0, in_word.sensi};

   // sensitivity split into an unsigned low half and a signed high half
   assign s7_pl_in = s6_d1_ff * s6_sd_ff[18:0];
   assign s7_ph_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sd_ff[37:19]);

   assign s8_prod_in = {s7_ph_ff[43:0], 19'b0} + {20'b0, s7_pl_ff};

   assign s9_press_in = s8_prod_ff[61:21] - {{2{s8_od_ff[38]}}, s8_od_ff};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s6_od_ff    <= s6_od_in;
         s6_sd_ff    <= s6_sd_in;
         s6_d1_ff    <= in_word.d1;
         s6_temp_ff  <= in_word.temp;
         s6_temp2_ff <= in_word.temp2;
         s6_dt_ff    <= in_word.dt;
      end
      if (en[1]) begin
         s7_pl_ff    <= s7_pl_in;
         s7_ph_ff    <= s7_ph_in;
         s7_od_ff    <= s6_od_ff;
         s7_temp_ff  <= s6_temp_ff;
         s7_temp2_ff <= s6_temp2_ff;
         s7_dt_ff    <= s6_dt_ff;
      end
      if (en[2]) begin
         s8_prod_ff  <= s8_prod_in;
         s8_od_ff    <= s7_od_ff;
         s8_temp_ff  <= s7_temp_ff;
         s8_temp2_ff <= s7_temp2_ff;
         s8_dt_ff    <= s7_dt_ff;
      end
      if (en[3]) begin
         s9_press_ff <= s9_press_in;
         s9_temp_ff  <= s8_temp_ff;
         s9_temp2_ff <= s8_temp2_ff;
         s9_dt_ff    <= s8_dt_ff;
      end
   end

endmodule

>>> rtl/pressure_temperature_compensation.sv
// Second-order pressure and temperature compensation for a 24-bit pressure
// sensor. Load the six 16-bit calibration words C1..C6 through the csr_ port
// (index 0..5, other indexes are ignored) while no sample is in flight, then
// send raw temperature/pressure pairs on req_. Each pair gives one rsp_ word
// with dT, the first-order and second-order temperature in hundredths of a
// degree, and the pressure in two's complement with 15 fraction bits. A new
// pair is taken every clock cycle unless a stall on rsp_ has filled the
// stages; each result passes through nine register stages that surround
// the dT products, the squared temperature error and the split D1 times
// sensitivity multiply. Stalls on rsp_ fill the empty stages first and only
// then hold off req_.
module pressure_temperature_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ptc_pkg::RAW_W-1:0]            req_raw_temperature,
   input  logic [ptc_pkg::RAW_W-1:0]            req_raw_pressure,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ptc_pkg::TEMP_W-1:0]    rsp_temperature_centi,
   output logic signed [ptc_pkg::TEMP_W-1:0]    rsp_first_order_temperature,
   output logic signed [ptc_pkg::DT_W-1:0]      rsp_delta_temperature,
   output logic signed [ptc_pkg::PRESS_W-1:0]   rsp_pressure_scaled
);
   import ptc_pkg::*;

   coef_type coef;
   mid_type  mid_word;
   logic     mid_valid;
   logic     mid_ready;

   ptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   ptc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_d2     (req_raw_temperature),
      .in_d1     (req_raw_pressure),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_word  (mid_word)
   );

   ptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_word   (mid_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_temp2 (rsp_temperature_centi),
      .out_temp  (rsp_first_order_temperature),
      .out_dt    (rsp_delta_temperature),
      .out_press (rsp_pressure_scaled)
   );

   // the low-temperature correction only ever lowers the temperature
   a_temp2_not_above: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_centi <= rsp_first_order_temperature))
      else $error("second-order temperature above first-order temperature");

   // at or above the reference temperature no correction applies
   a_no_corr_warm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_first_order_temperature >= $signed(TEMP_REF)))
         |-> (rsp_temperature_centi == rsp_first_order_temperature))
      else $error("temperature correction applied above reference");

   // with no word waiting at the output every stage can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

endmodule

>>> tb/pressure_temperature_compensation_tb.sv
`timescale 1ns / 100ps

module pressure_temperature_compensation_tb;
   import ptc_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_PAIRS  = 120;
   localparam int DRAIN_CYCLES = 12;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   localparam longint RAW_MAX      = (longint'(1) << RAW_W) - 1;
   localparam logic [COEF_W-1:0] COEF_MAX = '1;

   // compensation constants
   localparam longint TEMP_ZERO     = 2000;
   localparam int     TEMP_SHIFT    = 23;
   localparam int     REF_SHIFT     = 8;
   localparam int     OFF_SHIFT     = 17;
   localparam int     OFF_TC_SHIFT  = 6;
   localparam int     SENS_SHIFT    = 16;
   localparam int     SENS_TC_SHIFT = 7;
   localparam longint T_LOW_MUL     = 11;
   localparam int     T_LOW_SHIFT   = 35;
   localparam longint OFF_LOW_MUL   = 31;
   localparam int     OFF_LOW_SHIFT = 3;
   localparam longint SENS_LOW_MUL  = 63;
   localparam int     SENS_LOW_SHIFT = 5;
   localparam int     PRESS_SHIFT   = 21;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(7);

   typedef struct {
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } raw_pair_type;

   typedef struct {
      logic signed [TEMP_W-1:0]  temperature_centi;
      logic signed [TEMP_W-1:0]  first_order_temperature;
      logic signed [DT_W-1:0]    delta_temperature;
      logic signed [PRESS_W-1:0] pressure_scaled;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_C1;
   logic [COEF_W-1:0]         csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [RAW_W-1:0]          req_raw_temperature = '0;
   logic [RAW_W-1:0]          req_raw_pressure = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0]  rsp_temperature_centi;
   logic signed [TEMP_W-1:0]  rsp_first_order_temperature;
   logic signed [DT_W-1:0]    rsp_delta_temperature;
   logic signed [PRESS_W-1:0] rsp_pressure_scaled;

   raw_pair_type  pending_pairs[$];
   reading_type   expected_readings[$];
   coef_type   cal = '0;
   logic [COEF_W-1:0] setting [6];

   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_seg_left = 0;
   int   ready_pct = 100;

   int n_errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_cold = 0;
   int n_csr_writes = 0;
   int n_settings = 0;

   pressure_temperature_compensation dut (
      .clock                       (clock),
      .reset                       (reset),
      .csr_valid                   (csr_valid),
      .csr_ready                   (csr_ready),
      .csr_index                   (csr_index),
      .csr_wdata                   (csr_wdata),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_raw_temperature         (req_raw_temperature),
      .req_raw_pressure            (req_raw_pressure),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_temperature_centi       (rsp_temperature_centi),
      .rsp_first_order_temperature (rsp_first_order_temperature),
      .rsp_delta_temperature       (rsp_delta_temperature),
      .rsp_pressure_scaled         (rsp_pressure_scaled)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // second-order compensation of one raw pair with the current coefficients
   function automatic reading_type compensate(input logic [RAW_W-1:0] d2,
                                              input logic [RAW_W-1:0] d1);
      longint dt, temp, off, sens, t_low, off_low, sens_low, err, press;
      reading_type r;
      dt   = longint'({40'd0, d2}) - (longint'({48'd0, cal.c5}) << REF_SHIFT);
      temp = TEMP_ZERO + ((dt * longint'({48'd0, cal.c6})) >>> TEMP_SHIFT);
      off  = (longint'({48'd0, cal.c2}) << OFF_SHIFT)
           + ((longint'({48'd0, cal.c4}) * dt) >>> OFF_TC_SHIFT);
      sens = (longint'({48'd0, cal.c1}) << SENS_SHIFT)
           + ((longint'({48'd0, cal.c3}) * dt) >>> SENS_TC_SHIFT);
      t_low = 0;
      off_low = 0;
      sens_low = 0;
      if (temp < TEMP_ZERO) begin
         err      = temp - TEMP_ZERO;
         t_low    = (T_LOW_MUL * dt * dt) >>> T_LOW_SHIFT;
         off_low  = (OFF_LOW_MUL * err * err) >>> OFF_LOW_SHIFT;
         sens_low = (SENS_LOW_MUL * err * err) >>> SENS_LOW_SHIFT;
      end
      press = ((longint'({40'd0, d1}) * (sens - sens_low)) >>> PRESS_SHIFT)
            - (off - off_low);
      r.temperature_centi       = TEMP_W'(temp - t_low);
      r.first_order_temperature = TEMP_W'(temp);
      r.delta_temperature       = DT_W'(dt);
      r.pressure_scaled         = PRESS_W'(press);
      return r;
   endfunction

   function automatic logic [CSR_IDX_W-1:0] coef_index(input int i);
      case (i)
         0: return CSR_C1;
         1: return CSR_C2;
         2: return CSR_C3;
         3: return CSR_C4;
         4: return CSR_C5;
         default: return CSR_C6;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns, result %0d: %s", $time, n_checked, msg);
      n_errors++;
   endtask

   // sender: bursts of random length, random gaps between them
   always @(negedge clock) begin
      raw_pair_type pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0 || pending_pairs.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            pair = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_raw_temperature <= pair.raw_temperature;
            req_raw_pressure <= pair.raw_pressure;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: segments with their own ready probability
   always @(negedge clock) begin
      if (stall_seg_left == 0) begin
         stall_seg_left <= $urandom_range(4, 60);
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 80;
            2: ready_pct <= 40;
            default: ready_pct <= 10;
         endcase
      end else begin
         stall_seg_left <= stall_seg_left - 1;
      end
      rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
   end

   always @(posedge clock) begin
      reading_type want;
      req_fire <= !reset && req_valid && req_ready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            n_csr_writes++;
            case (csr_index)
               CSR_C1: cal.c1 <= csr_wdata;
               CSR_C2: cal.c2 <= csr_wdata;
               CSR_C3: cal.c3 <= csr_wdata;
               CSR_C4: cal.c4 <= csr_wdata;
               CSR_C5: cal.c5 <= csr_wdata;
               CSR_C6: cal.c6 <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
            n_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature_centi !== want.temperature_centi)
                  report_mismatch($sformatf("temperature_centi got %0d expected %0d",
                                            rsp_temperature_centi, want.temperature_centi));
               if (rsp_first_order_temperature !== want.first_order_temperature)
                  report_mismatch($sformatf("first_order_temperature got %0d expected %0d",
                                            rsp_first_order_temperature,
                                            want.first_order_temperature));
               if (rsp_delta_temperature !== want.delta_temperature)
                  report_mismatch($sformatf("delta_temperature got %0d expected %0d",
                                            rsp_delta_temperature, want.delta_temperature));
               if (rsp_pressure_scaled !== want.pressure_scaled)
                  report_mismatch($sformatf("pressure_scaled got %0d expected %0d",
                                            rsp_pressure_scaled, want.pressure_scaled));
               if (want.first_order_temperature < TEMP_ZERO) n_cold++;
               n_checked++;
            end
         end
      end
   end

   task automatic push_pair(input longint t, input longint p);
      pending_pairs.push_back('{raw_temperature: RAW_W'(t), raw_pressure: RAW_W'(p)});
   endtask

   // nothing queued, nothing on the wire, nothing in the pipeline
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_pairs.size() != 0 || req_valid || expected_readings.size() != 0);
   endtask

   // call at a falling edge; leaves valid high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_fire);
   endtask

   task automatic program_coefs(input int rot, input bit spare);
      int k;
      @(negedge clock);
      if (spare)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                   COEF_W'($urandom_range(0, 65535)));
      for (int i = 0; i < 6; i++) begin
         k = (i + rot) % 6;
         write_reg(coef_index(k), setting[k]);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      longint centre, d2, d1, span;
      int pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero coefficients straight out of reset
      push_pair(0, 0);
      push_pair(RAW_MAX, RAW_MAX);
      push_pair(0, RAW_MAX);
      push_pair(RAW_MAX, 0);
      push_pair(24'hAAAAAA, 24'h555555);
      wait_idle();

      // typical calibration; spare indexes written first must change nothing
      setting = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
      @(negedge clock);
      write_reg(CSR_SPARE_LO, COEF_MAX);
      write_reg(CSR_SPARE_HI, COEF_MAX);
      csr_valid <= 1'b0;
      program_coefs(0, 1'b0);
      centre = longint'(setting[4]) << REF_SHIFT;
      push_pair(centre, 24'h800000);
      push_pair(centre - 1, RAW_MAX);
      push_pair(centre + 1, RAW_MAX);
      push_pair(0, RAW_MAX);
      push_pair(0, 0);
      push_pair(RAW_MAX, RAW_MAX);
      push_pair(RAW_MAX, 0);
      push_pair(centre - 24'h100000, 24'h8A0000);
      wait_idle();

      // all-ones coefficients
      setting = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
      program_coefs(3, 1'b0);
      push_pair(0, RAW_MAX);
      push_pair(RAW_MAX, RAW_MAX);
      push_pair(longint'(COEF_MAX) << REF_SHIFT, 0);
      push_pair(24'h800000, RAW_MAX);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         for (int i = 0; i < 6; i++) begin
            pick = $urandom_range(0, 9);
            setting[i] = (pick == 0) ? '0 : (pick == 1) ? COEF_MAX
                                             : COEF_W'($urandom_range(0, 65535));
         end
         program_coefs($urandom_range(0, 5), $urandom_range(0, 2) == 0);
         centre = longint'(setting[4]) << REF_SHIFT;
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               d2 = longint'($urandom_range(0, 32'(RAW_MAX)));
            end else if (pick < 8) begin
               // around the reference so both sides of 20.00 C show up
               span = longint'(1) << $urandom_range(4, 22);
               d2 = centre + longint'($urandom_range(0, 32'(span))) - span / 2;
               if (d2 < 0) d2 = 0;
               if (d2 > RAW_MAX) d2 = RAW_MAX;
            end else begin
               d2 = $urandom_range(0, 1) ? RAW_MAX : 0;
            end
            pick = $urandom_range(0, 9);
            d1 = (pick == 0) ? 0 : (pick == 1) ? RAW_MAX
                                 : longint'($urandom_range(0, 32'(RAW_MAX)));
            push_pair(d2, d1);
         end
         // no new pairs are queued until every result is back
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d raw pairs, %0d results checked, %0d of them below 20.00 C",
               n_sent, n_checked, n_cold);
      $display("%0d register writes over %0d calibrations plus the all-zero reset state",
               n_csr_writes, n_settings);
      if (n_errors == 0 && expected_readings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout after %0d ns", RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
